/* src/spn_pkg.sv */
// Shared types and constants of the salt-and-pepper noise block.
// Holds the generator constants, register map and configuration struct.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package spn_pkg;

  // Park-Miller minimal standard generator
  localparam logic [30:0] LCG_MOD  = 31'h7FFF_FFFF;
  localparam logic [14:0] LCG_MULT = 15'd16807;

  // APB register map
  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;

  typedef enum logic [2:0] {
    REG_SEED   = 3'd0,
    REG_SALT   = 3'd1,
    REG_PEPPER = 3'd2,
    REG_LOW    = 3'd3,
    REG_HIGH   = 3'd4
  } reg_idx_e;

  // Register reset values
  localparam logic [30:0] SEED_RST   = 31'd1;
  localparam logic [30:0] SALT_RST   = 31'd0;
  localparam logic [30:0] PEPPER_RST = 31'h7FFF_FFFF;
  localparam logic [15:0] LOW_RST    = 16'h0000;
  localparam logic [15:0] HIGH_RST   = 16'hFFFF;

  typedef struct packed {
    logic [30:0] seed;
    logic [30:0] salt;
    logic [30:0] pepper;
    logic [15:0] low_val;
    logic [15:0] high_val;
  } cfg_t;

endpackage

`default_nettype wire

/* src/spn_if.sv */
// Valid/ready channel interfaces for pixel items and noisy results.
// Depends on nothing; the pixel width follows the PIXEL_BITS parameter.
`timescale 1ns / 1ps
`default_nettype none

interface spn_in_if #(
  parameter int unsigned PIXEL_BITS = 16
) ();
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] pixel_in;

  modport source (output valid, output pixel_in, input ready);
  modport sink   (input valid, input pixel_in, output ready);
endinterface

interface spn_out_if #(
  parameter int unsigned PIXEL_BITS = 16
) ();
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] pixel_out;
  logic [30:0]           deviate;

  modport source (output valid, output pixel_out, output deviate, input ready);
  modport sink   (input valid, input pixel_out, input deviate, output ready);
endinterface

`default_nettype wire

/* src/salt_pepper_noise_shuffled_lcg.sv */
// Salt-and-pepper noise stage with a shuffled Park-Miller generator.
// Channels: in_i carries one pixel component per transfer, out_o returns the
// pixel after replacement and the deviate drawn for it; both are valid/ready.
// The APB port sets seed, salt and pepper thresholds and the low and high
// replacement values; pready is always high and writes complete in the access
// cycle. Write registers only while the block is idle.
// One item is in flight at a time. A drawn item passes from its input transfer
// through the table read, the table write-back with the next shuffle index and
// the output load to a valid result. The next item can be taken in the cycle
// after the result loads.
// The first item after reset or after a seed write fills the table first: a
// load step, TABLE_SIZE+8 generator steps of a multiply and a reduce each, and
// an index step, before the table read of the draw.
// Reset clears the control state; the table is undefined until that fill.
// A stalled receiver holds the result in the output register; one new item is
// still taken meanwhile and waits in its last step until the register frees.
// Depends on spn_pkg, spn_if and spn_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module salt_pepper_noise_shuffled_lcg import spn_pkg::*; #(
  parameter int unsigned TABLE_SIZE = 32,
  parameter int unsigned PIXEL_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  spn_in_if.sink            in_i,
  spn_out_if.source         out_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t cfg_q, cfg_d;
  logic cfg_wr;
  logic seed_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  // Decode register writes
  always_comb begin
    cfg_d   = cfg_q;
    seed_wr = 1'b0;
    if (cfg_wr) begin
      unique case (paddr[4:2])
        REG_SEED: begin
          cfg_d.seed = pwdata[30:0];
          seed_wr    = 1'b1;
        end
        REG_SALT:   cfg_d.salt     = pwdata[30:0];
        REG_PEPPER: cfg_d.pepper   = pwdata[30:0];
        REG_LOW:    cfg_d.low_val  = pwdata[15:0];
        REG_HIGH:   cfg_d.high_val = pwdata[15:0];
        default: begin
          cfg_d = cfg_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.seed     <= SEED_RST;
      cfg_q.salt     <= SALT_RST;
      cfg_q.pepper   <= PEPPER_RST;
      cfg_q.low_val  <= LOW_RST;
      cfg_q.high_val <= HIGH_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read back registers
  always_comb begin
    unique case (paddr[4:2])
      REG_SEED:   prdata = DATA_W'(cfg_q.seed);
      REG_SALT:   prdata = DATA_W'(cfg_q.salt);
      REG_PEPPER: prdata = DATA_W'(cfg_q.pepper);
      REG_LOW:    prdata = DATA_W'(cfg_q.low_val);
      REG_HIGH:   prdata = DATA_W'(cfg_q.high_val);
      default:    prdata = '0;
    endcase
  end

  spn_ctrl #(
    .TABLE_SIZE (TABLE_SIZE),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .seed_wr_i (seed_wr),
    .in_i      (in_i),
    .out_o     (out_o)
  );

endmodule

`default_nettype wire

/* src/spn_lcg.sv */
// Park-Miller step unit: registered 31x15 product, then Mersenne fold.
// Depends on spn_pkg for the multiplier and modulus.
`timescale 1ns / 1ps
`default_nettype none

module spn_lcg import spn_pkg::*; (
  input  logic        clk_i,
  input  logic [30:0] val_i,
  output logic [30:0] next_o
);

  logic [45:0] prod_q;
  logic [31:0] fold;

  // Register the product of the current value every cycle
  always_ff @(posedge clk_i) begin
    prod_q <= {15'd0, val_i} * {31'd0, LCG_MULT};
  end

  // Fold modulo 2^31-1: high part plus low part, one conditional subtract
  always_comb begin
    fold = 32'(prod_q[45:31]) + 32'(prod_q[30:0]);
    if (fold >= 32'(LCG_MOD)) begin
      next_o = 31'(fold - 32'(LCG_MOD));
    end else begin
      next_o = fold[30:0];
    end
  end

endmodule

`default_nettype wire

/* src/spn_idxdiv.sv */
// Shuffle index unit: quotient of a table value by the bucket size, found by
// comparing against the constant bucket bounds. Depends on nothing beyond its parameter.
`timescale 1ns / 1ps
`default_nettype none

module spn_idxdiv #(
  parameter int unsigned TABLE_SIZE = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [30:0]                   dividend_i,
  output logic                          done_o,
  output logic [$clog2(TABLE_SIZE)-1:0] quot_o
);

  localparam int unsigned IdxW = $clog2(TABLE_SIZE);
  localparam longint unsigned Divisor = 64'd1 + 64'd2147483646 / TABLE_SIZE;

  logic            done_q;
  logic [IdxW-1:0] quot_q;
  logic [IdxW-1:0] quot_d;

  // Bucket bounds rise with k, so the last bound reached gives the quotient
  always_comb begin
    quot_d = '0;
    for (int unsigned k = 1; k < TABLE_SIZE; k++) begin
      if (64'(dividend_i) >= 64'(k) * Divisor) begin
        quot_d = IdxW'(k);
      end
    end
  end

  // Flag a valid quotient from the first start on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else if (start_i) begin
      done_q <= 1'b1;
    end
  end

  // Hold the quotient until the next start
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= quot_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

`default_nettype wire

/* src/spn_ctrl.sv */
// Sequencer around the shuffle table memory: table fill, read-modify-write
// draw, noise decision and output register. Depends on spn_pkg, spn_if,
// spn_lcg and spn_idxdiv.
`timescale 1ns / 1ps
`default_nettype none

module spn_ctrl import spn_pkg::*; #(
  parameter int unsigned TABLE_SIZE = 32,
  parameter int unsigned PIXEL_BITS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       seed_wr_i,
  spn_in_if.sink     in_i,
  spn_out_if.source  out_o
);

  localparam int unsigned IdxW = $clog2(TABLE_SIZE);
  localparam int unsigned CntW = $clog2(TABLE_SIZE + 8);
  localparam logic [CntW-1:0] FillLast = CntW'(TABLE_SIZE + 7);
  localparam logic [IdxW-1:0] IdxMax = IdxW'(TABLE_SIZE - 1);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_LOAD = 8'b0000_0010,
    S_FMUL = 8'b0000_0100,
    S_FRED = 8'b0000_1000,
    S_DIVW = 8'b0001_0000,
    S_RD   = 8'b0010_0000,
    S_WB   = 8'b0100_0000,
    S_OUT  = 8'b1000_0000
  } state_e;

  state_e                state_q, state_d;
  logic [30:0]           lcg_q, lcg_d;
  logic [30:0]           sout_q, sout_d;
  logic                  rdy_q, rdy_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic [PIXEL_BITS-1:0] pix_q;
  logic                  out_vld_q;
  logic [PIXEL_BITS-1:0] out_pix_q;
  logic [30:0]           out_dev_q;

  logic [30:0]     tbl_mem [TABLE_SIZE];
  logic [30:0]     rdata_q;
  logic            mem_we;
  logic [IdxW-1:0] mem_waddr;
  logic [30:0]     mem_wdata;

  logic [30:0]           lcg_next;
  logic                  div_start;
  logic [30:0]           div_dividend;
  logic                  div_done;
  logic [IdxW-1:0]       div_quot;
  logic [IdxW-1:0]       idx;
  logic                  accept;
  logic                  out_load;
  logic [PIXEL_BITS-1:0] res_pix;

  spn_lcg u_lcg (
    .clk_i  (clk_i),
    .val_i  (lcg_q),
    .next_o (lcg_next)
  );

  spn_idxdiv #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_idxdiv (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // Clamp the index to the last entry
  assign idx = (32'(div_quot) > 32'(TABLE_SIZE - 1)) ? IdxMax : div_quot;

  assign in_i.ready = (state_q == S_IDLE) && (!rdy_q || div_done);
  assign accept     = in_i.valid && in_i.ready;
  assign out_load   = (state_q == S_OUT) && (!out_vld_q || out_o.ready);

  // Salt first, pepper overrides
  always_comb begin
    res_pix = pix_q;
    if (sout_q < cfg_i.salt) begin
      res_pix = PIXEL_BITS'(cfg_i.high_val);
    end
    if (sout_q >= cfg_i.pepper) begin
      res_pix = PIXEL_BITS'(cfg_i.low_val);
    end
  end

  // Sequencer
  always_comb begin
    state_d      = state_q;
    lcg_d        = lcg_q;
    sout_d       = sout_q;
    rdy_d        = rdy_q;
    cnt_d        = cnt_q;
    mem_we       = 1'b0;
    mem_waddr    = idx;
    mem_wdata    = lcg_next;
    div_start    = 1'b0;
    div_dividend = rdata_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = rdy_q ? S_RD : S_LOAD;
        end
      end
      S_LOAD: begin
        lcg_d   = (cfg_i.seed == '0) ? 31'd1 : cfg_i.seed;
        cnt_d   = FillLast;
        state_d = S_FMUL;
      end
      S_FMUL: begin
        state_d = S_FRED;
      end
      S_FRED: begin
        lcg_d = lcg_next;
        if (32'(cnt_q) < TABLE_SIZE) begin
          mem_we    = 1'b1;
          mem_waddr = cnt_q[IdxW-1:0];
        end
        if (cnt_q == '0) begin
          sout_d       = lcg_next;
          rdy_d        = 1'b1;
          div_start    = 1'b1;
          div_dividend = lcg_next;
          state_d      = S_DIVW;
        end else begin
          cnt_d   = cnt_q - 1'b1;
          state_d = S_FMUL;
        end
      end
      S_DIVW: begin
        if (div_done) begin
          state_d = S_RD;
        end
      end
      S_RD: begin
        state_d = S_WB;
      end
      S_WB: begin
        mem_we    = 1'b1;
        lcg_d     = lcg_next;
        sout_d    = rdata_q;
        div_start = 1'b1;
        state_d   = S_OUT;
      end
      S_OUT: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    // A seed write restarts the table fill on the next item
    if (seed_wr_i) begin
      rdy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      lcg_q     <= '0;
      sout_q    <= '0;
      rdy_q     <= 1'b0;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      lcg_q   <= lcg_d;
      sout_q  <= sout_d;
      rdy_q   <= rdy_d;
      cnt_q   <= cnt_d;
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Capture the pixel and the result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      pix_q <= in_i.pixel_in;
    end
    if (out_load) begin
      out_pix_q <= res_pix;
      out_dev_q <= sout_q;
    end
  end

  // Shuffle table: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      tbl_mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= tbl_mem[idx];
  end

  assign out_o.valid     = out_vld_q;
  assign out_o.pixel_out = out_pix_q;
  assign out_o.deviate   = out_dev_q;

endmodule

`default_nettype wire

/* src/spn_checker.sv */
// Port-level checks for the salt-and-pepper noise block, bound to its top.
// Depends on the top level's channel ports only.
`timescale 1ns / 1ps
`default_nettype none

module spn_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [30:0] out_deviate_i
);

  logic in_xfer;
  assign in_xfer = in_valid_i && in_ready_i;

  // Held result keeps its deviate while the receiver stalls
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_deviate_i))
    else $error("result changed while stalled");

  // One item at a time: no input transfer right after another
  a_in_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !in_ready_i)
    else $error("input taken on consecutive cycles");

  // A result never appears in the cycle after an input transfer
  a_out_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !$rose(out_valid_i))
    else $error("result rose too early");

  // The generator never reaches the modulus
  a_dev_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_deviate_i != 31'h7FFF_FFFF)
    else $error("deviate out of range");

endmodule

bind salt_pepper_noise_shuffled_lcg spn_checker u_spn_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_deviate_i (out_o.deviate)
);

`default_nettype wire

/* verif/salt_pepper_noise_shuffled_lcg_tb.sv */
// Self-checking bench for the salt-and-pepper noise stage with its shuffled generator.
// Predicts pixel_out and deviate per transfer, varies the APB registers between phases.
// Depends on spn_pkg, spn_if and the salt_pepper_noise_shuffled_lcg top level.
`timescale 1ns / 1ps

module salt_pepper_noise_shuffled_lcg_tb;
  import spn_pkg::*;

  localparam int unsigned TBL_ENTRIES = 32;
  localparam int unsigned PIX_W = 16;
  localparam longint unsigned SHUF_DIV = 64'd1 + (64'(LCG_MOD) - 64'd1) / TBL_ENTRIES;
  // Address slot that maps to no register
  localparam logic [2:0] REG_NONE = 3'd7;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned RAND_PHASES = 12;
  localparam int unsigned PHASE_ITEMS = 86;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic [30:0]      dev;
  } noisy_px_t;

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  spn_in_if  #(.PIXEL_BITS(PIX_W)) in_if ();
  spn_out_if #(.PIXEL_BITS(PIX_W)) out_if ();

  salt_pepper_noise_shuffled_lcg #(
    .TABLE_SIZE(TBL_ENTRIES),
    .PIXEL_BITS(PIX_W)
  ) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // Predictor state: register copy and generator with its shuffle table
  cfg_t        model_cfg;
  logic [30:0] gen_state;
  logic [30:0] shuf_last;
  logic [30:0] shuf_tab [TBL_ENTRIES];
  bit          tab_filled;

  logic [PIX_W-1:0] pixel_queue [$];
  noisy_px_t        noisy_expect [$];
  noisy_px_t        want_px;

  bit          in_xfer;
  int unsigned in_idle_pct;
  int unsigned out_idle_pct;
  int unsigned gap_left;
  int unsigned stall_left;
  int unsigned err_count = 0;
  int unsigned items_in = 0;
  int unsigned results_seen = 0;
  int unsigned cfg_writes = 0;
  int unsigned n_salt = 0;
  int unsigned n_pepper = 0;
  int unsigned n_clean = 0;
  int unsigned cycle_count = 0;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic logic [30:0] park_miller_step(logic [30:0] v);
    longint unsigned prod;
    prod = 64'(v) * 64'(LCG_MULT);
    return 31'(prod % 64'(LCG_MOD));
  endfunction

  // Refill the table if needed, draw one shuffled deviate, queue the noisy pixel
  function void draw_noisy(logic [PIX_W-1:0] pix);
    longint unsigned idx;
    noisy_px_t       res;
    if (!tab_filled) begin
      gen_state = (model_cfg.seed == 31'd0) ? 31'd1 : model_cfg.seed;
      for (int j = TBL_ENTRIES + 7; j >= 0; j--) begin
        gen_state = park_miller_step(gen_state);
        if (j < TBL_ENTRIES) shuf_tab[j] = gen_state;
      end
      shuf_last  = shuf_tab[0];
      tab_filled = 1'b1;
    end
    gen_state = park_miller_step(gen_state);
    idx = 64'(shuf_last) / SHUF_DIV;
    if (idx >= TBL_ENTRIES) idx = TBL_ENTRIES - 1;
    res.dev       = shuf_tab[idx];
    shuf_last     = res.dev;
    shuf_tab[idx] = gen_state;
    res.pixel     = pix;
    if (res.dev < model_cfg.salt) res.pixel = model_cfg.high_val;
    // pepper overrides salt when both thresholds are met
    if (res.dev >= model_cfg.pepper) res.pixel = model_cfg.low_val;
    if (res.dev >= model_cfg.pepper) n_pepper++;
    else if (res.dev < model_cfg.salt) n_salt++;
    else n_clean++;
    noisy_expect.push_back(res);
  endfunction

  // Track transfers on both channels and check each result against the oldest prediction
  always @(posedge clk_i) begin
    in_xfer <= in_if.valid && in_if.ready;
    if (in_if.valid && in_if.ready) begin
      draw_noisy(in_if.pixel_in);
      items_in++;
    end
    if (out_if.valid && out_if.ready) begin
      if (noisy_expect.size() == 0) begin
        $error("result with nothing expected: pixel_out %h deviate %h",
               out_if.pixel_out, out_if.deviate);
        err_count++;
      end else begin
        want_px = noisy_expect.pop_front();
        results_seen++;
        if (out_if.pixel_out !== want_px.pixel) begin
          $error("pixel_out mismatch: expected %h, actual %h", want_px.pixel, out_if.pixel_out);
          err_count++;
        end
        if (out_if.deviate !== want_px.dev) begin
          $error("deviate mismatch: expected %h, actual %h", want_px.dev, out_if.deviate);
          err_count++;
        end
      end
    end
  end

  // Drive pixel transfers from the queue, with random gaps between them
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_xfer) begin
      if (gap_left > 0) begin
        in_if.valid <= 1'b0;
        gap_left--;
      end else if (pixel_queue.size() > 0) begin
        if (in_idle_pct > 0 && $urandom_range(99) < in_idle_pct) begin
          gap_left = $urandom_range(10, 1) - 1;
          in_if.valid <= 1'b0;
        end else begin
          in_if.valid    <= 1'b1;
          in_if.pixel_in <= pixel_queue.pop_front();
        end
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Stall the result channel in random bursts
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_if.ready <= 1'b0;
      stall_left--;
    end else if (out_idle_pct > 0 && $urandom_range(99) < out_idle_pct) begin
      stall_left = $urandom_range(10, 1) - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // Bound the run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $error("no progress within %0d cycles", CYCLE_LIMIT);
      $display("simulation failed");
      $finish;
    end
  end

  // APB write: setup cycle, then access cycle; unused bits carry random data
  task automatic cfg_write(logic [2:0] idx, logic [30:0] val);
    logic [31:0] noise;
    logic [31:0] data;
    noise = $urandom();
    if (idx == REG_LOW || idx == REG_HIGH) data = {noise[31:16], val[15:0]};
    else data = {noise[31], val};
    @(negedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_SEED: begin
        model_cfg.seed = data[30:0];
        tab_filled     = 1'b0;
      end
      REG_SALT:   model_cfg.salt     = data[30:0];
      REG_PEPPER: model_cfg.pepper   = data[30:0];
      REG_LOW:    model_cfg.low_val  = data[15:0];
      REG_HIGH:   model_cfg.high_val = data[15:0];
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Hold until every queued pixel has gone in and every result has come back
  task automatic drain_results();
    do @(posedge clk_i);
    while (pixel_queue.size() != 0 || in_if.valid || noisy_expect.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [30:0] pick_threshold(bit low_side);
    case ($urandom_range(5))
      0: return 31'd0;
      1: return LCG_MOD;
      2, 3: begin
        if (low_side) return 31'($urandom_range(32'h2000_0000));
        return LCG_MOD - 31'($urandom_range(32'h2000_0000));
      end
      default: return 31'($urandom());
    endcase
  endfunction

  function automatic logic [30:0] pick_seed();
    case ($urandom_range(5))
      0: return 31'd0;
      1: return LCG_MOD;
      2: return 31'd1;
      default: return 31'($urandom());
    endcase
  endfunction

  function automatic logic [15:0] pick_level();
    case ($urandom_range(3))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom());
    endcase
  endfunction

  initial begin
    rst_ni         = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    in_if.valid    = 1'b0;
    in_if.pixel_in = '0;
    out_if.ready   = 1'b0;
    in_xfer        = 1'b0;
    gap_left       = 0;
    stall_left     = 0;
    in_idle_pct    = 20;
    out_idle_pct   = 20;
    model_cfg      = '{seed: SEED_RST, salt: SALT_RST, pepper: PEPPER_RST,
                       low_val: LOW_RST, high_val: HIGH_RST};
    gen_state      = '0;
    shuf_last      = '0;
    tab_filled     = 1'b0;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset settings: table fill from seed one, pixels pass through
    pixel_queue = '{16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF, 16'h5555, 16'hAAAA};
    drain_results();

    // Salt everywhere
    cfg_write(REG_SALT, LCG_MOD);
    cfg_write(REG_HIGH, 16'h0001);
    pixel_queue = '{16'h0000, 16'hFFFF, 16'h1234};
    drain_results();

    // Both thresholds met: pepper wins
    cfg_write(REG_PEPPER, 31'd0);
    cfg_write(REG_LOW, 16'hFFFF);
    pixel_queue = '{16'h0000, 16'hFFFF, 16'h4321};
    drain_results();

    // Zero seed behaves as seed one
    cfg_write(REG_SEED, 31'd0);
    cfg_write(REG_SALT, 31'd0);
    cfg_write(REG_PEPPER, LCG_MOD);
    cfg_write(REG_LOW, 16'h0000);
    cfg_write(REG_HIGH, 16'hFFFF);
    pixel_queue = '{16'h0F0F, 16'hF0F0, 16'h00FF};
    drain_results();

    // All-ones seed locks the generator at zero; unmapped slot is ignored
    cfg_write(REG_SEED, LCG_MOD);
    cfg_write(REG_SALT, 31'd1);
    cfg_write(REG_NONE, 31'($urandom()));
    pixel_queue = '{16'h0001, 16'hFFFE};
    drain_results();
    cfg_write(REG_PEPPER, 31'd0);
    pixel_queue = '{16'h0002, 16'hFFFD};
    drain_results();

    // Mid-range thresholds from a random seed
    cfg_write(REG_SEED, 31'($urandom()));
    cfg_write(REG_SALT, 31'h4000_0000);
    cfg_write(REG_PEPPER, 31'h6000_0000);
    pixel_queue = '{16'h1111, 16'h2222, 16'h3333, 16'h4444};
    drain_results();

    // Random phases, each with its own register setting
    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      if (phase == RAND_PHASES - 1 || phase % 4 == 2) begin
        in_idle_pct  = 0;
        out_idle_pct = 0;
      end else begin
        in_idle_pct  = $urandom_range(40, 5);
        out_idle_pct = $urandom_range(40, 5);
      end
      if (phase == 0 || $urandom_range(1)) cfg_write(REG_SEED, pick_seed());
      cfg_write(REG_SALT, pick_threshold(1'b1));
      cfg_write(REG_PEPPER, pick_threshold(1'b0));
      cfg_write(REG_LOW, pick_level());
      cfg_write(REG_HIGH, pick_level());
      for (int k = 0; k < PHASE_ITEMS; k++) pixel_queue.push_back(16'($urandom()));
      drain_results();
    end

    $display("covered %0d pixel transfers, %0d results checked, %0d register writes",
             items_in, results_seen, cfg_writes);
    $display("outcomes: %0d salt, %0d pepper, %0d unchanged", n_salt, n_pepper, n_clean);
    if (err_count == 0 && noisy_expect.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/spn_pkg.sv
src/spn_if.sv
src/spn_lcg.sv
src/spn_idxdiv.sv
src/spn_ctrl.sv
src/salt_pepper_noise_shuffled_lcg.sv
src/spn_checker.sv
verif/salt_pepper_noise_shuffled_lcg_tb.sv
